### rtl/core/bmsrfp_pkg.sv
// Shared types and constants of the response frame parser.
// Used by the front, queue and back modules; depends on nothing.
`default_nettype none
package bmsrfp_pkg;

    typedef enum logic [2:0] {
        PH_TYPE      = 3'd0,
        PH_VALUE     = 3'd1,
        PH_CELLCOUNT = 3'd2,
        PH_CELLIDX   = 3'd3,
        PH_CELLVAL   = 3'd4,
        PH_STRING    = 3'd5
    } phase_t;

    typedef enum logic [3:0] {
        K_NONE, K_U8, K_BOOL, K_U16, K_U16X10, K_S16, K_U32, K_TEMP, K_CUR, K_CELL, K_STR
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_BAD_START = 3'd1, ST_BAD_LEN = 3'd2, ST_BAD_END = 3'd3,
        ST_BAD_SUM = 3'd4
    } status_t;

    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_END   = 2'd1;
    localparam logic [1:0] REG_VER   = 2'd2;

    localparam logic [7:0]  TYPE_CELL   = 8'h79;
    localparam logic [7:0]  TYPE_NAME   = 8'hba;
    localparam logic [16:0] OFFSET_MAX  = 17'h1FFFF;
    localparam logic [16:0] DATA_START  = 17'd11;

    // Work item from the front to the back.
    typedef struct packed {
        logic        is_verdict;
        logic [7:0]  field_type;
        logic [7:0]  element_index;
        kind_t       kind;
        logic [31:0] acc;
        logic [7:0]  version;
        logic [2:0]  status;
    } job_t;

    typedef struct packed {
        kind_t      kind;
        logic [4:0] len;
    } kind_len_t;

    function automatic kind_len_t kind_of(input logic [7:0] t);
        kind_len_t r;
        r.kind = K_NONE;
        r.len  = 5'd0;
        if (t == 8'h79) r.kind = K_CELL;
        else if (t >= 8'h80 && t <= 8'h82) begin r.kind = K_TEMP; r.len = 5'd2; end
        else if (t == 8'h84) begin r.kind = K_CUR; r.len = 5'd2; end
        else if (t == 8'h83 || t == 8'h8e || t == 8'h8f) begin
            r.kind = K_U16X10; r.len = 5'd2;
        end else if (t >= 8'ha5 && t <= 8'ha8) begin r.kind = K_S16; r.len = 5'd2; end
        else if (t == 8'h89 || t == 8'haa || t == 8'hb6 || t == 8'hb9) begin
            r.kind = K_U32; r.len = 5'd4;
        end else if (t == 8'h85 || t == 8'h86 || t == 8'ha9 || t == 8'hae || t == 8'haf ||
                     t == 8'hb1 || t == 8'hc0) begin
            r.kind = K_U8; r.len = 5'd1;
        end else if (t == 8'h9d || t == 8'hab || t == 8'hac || t == 8'hb3 || t == 8'hb8) begin
            r.kind = K_BOOL; r.len = 5'd1;
        end else if (t == 8'h87 || t == 8'h8a || t == 8'h8b || t == 8'h8c ||
                     (t >= 8'h90 && t <= 8'h9c) || (t >= 8'h9e && t <= 8'ha4) ||
                     t == 8'had || t == 8'hb0) begin
            r.kind = K_U16; r.len = 5'd2;
        end else if (t == 8'hb2) begin r.kind = K_STR; r.len = 5'd10; end
        else if (t == 8'hb4) begin r.kind = K_STR; r.len = 5'd8; end
        else if (t == 8'hb5) begin r.kind = K_STR; r.len = 5'd4; end
        else if (t == 8'hb7) begin r.kind = K_STR; r.len = 5'd15; end
        else if (t == 8'hba) begin r.kind = K_STR; r.len = 5'd24; end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/core/bmsrfp_front.sv
// Front end: frame tracking, header checks, checksum and field tokenizing.
// Depends on bmsrfp_pkg; emits raw jobs for bmsrfp_back.
`default_nettype none
module bmsrfp_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_fire,
    input  wire logic [7:0]         data_byte,
    input  wire logic               frame_end,
    input  wire logic [15:0]        start_marker,
    input  wire logic [7:0]         end_marker,
    input  wire logic [7:0]         protocol_version,
    output logic                    job_valid,
    output bmsrfp_pkg::job_t        job
);

    logic [16:0]        byte_offset_reg;
    logic [15:0]        declared_length_reg;
    logic [15:0]        running_sum_reg;
    logic [15:0]        header_word_reg;
    logic               start_ok_reg;
    logic               end_ok_reg;
    bmsrfp_pkg::phase_t parse_phase_reg;
    logic [7:0]         current_type_reg;
    logic [4:0]         bytes_left_reg;
    logic [31:0]        value_acc_reg;
    logic [6:0]         cells_left_reg;
    logic [7:0]         element_counter_reg;

    logic [16:0]        byte_offset_next;
    logic [15:0]        declared_length_next;
    logic [15:0]        running_sum_next;
    logic [15:0]        header_word_next;
    logic               start_ok_next;
    logic               end_ok_next;
    bmsrfp_pkg::phase_t parse_phase_next;
    logic [7:0]         current_type_next;
    logic [4:0]         bytes_left_next;
    logic [31:0]        value_acc_next;
    logic [6:0]         cells_left_next;
    logic [7:0]         element_counter_next;

    logic [16:0] off;
    logic [17:0] dl_ext;
    logic        in_data;
    logic        field_fire;
    logic [7:0]  field_idx;
    bmsrfp_pkg::kind_len_t kl_b;
    bmsrfp_pkg::kind_len_t kl_cur;
    logic [4:0]  bl_dec;
    logic [15:0] div3_prod;
    logic [7:0]  str_char;
    logic [16:0] sz;
    logic [17:0] sz_ext;
    logic        sok;
    logic [2:0]  status;
    logic [7:0]  hb [4];
    logic [16:0] pos;
    logic [15:0] sum_adj;

    assign off    = byte_offset_reg;
    assign dl_ext = {2'b00, declared_length_next};
    assign kl_b   = bmsrfp_pkg::kind_of(data_byte);
    assign kl_cur = bmsrfp_pkg::kind_of(current_type_reg);
    assign bl_dec = (bytes_left_reg != 5'd0) ? bytes_left_reg - 5'd1 : 5'd0;
    // count/3 for a byte: multiply by 171, drop 9 bits (exact over 0..255)
    assign div3_prod = {8'd0, data_byte} * 16'd171;

    // Per-byte frame and field tokenizer
    always_comb begin
        header_word_next     = header_word_reg;
        declared_length_next = declared_length_reg;
        running_sum_next     = running_sum_reg;
        start_ok_next        = start_ok_reg;
        end_ok_next          = end_ok_reg;
        parse_phase_next     = parse_phase_reg;
        current_type_next    = current_type_reg;
        bytes_left_next      = bytes_left_reg;
        value_acc_next       = value_acc_reg;
        cells_left_next      = cells_left_reg;
        element_counter_next = element_counter_reg;
        field_fire           = 1'b0;
        field_idx            = 8'd0;
        str_char             = data_byte;

        if (off < 17'd2) begin
            header_word_next = {header_word_reg[7:0], data_byte};
            if (off == 17'd1) start_ok_next = ({header_word_reg[7:0], data_byte} == start_marker);
        end else if (off < 17'd4) begin
            declared_length_next = {declared_length_reg[7:0], data_byte};
        end
        if (off < 17'd4 || ({1'b0, off} + 18'd2) < dl_ext)
            running_sum_next = running_sum_reg + {8'd0, data_byte};
        if (off >= 17'd4 && ({1'b0, off} + 18'd3) == dl_ext)
            end_ok_next = (data_byte == end_marker);

        in_data = start_ok_next && off >= bmsrfp_pkg::DATA_START &&
                  ({1'b0, off} + 18'd7) < dl_ext;

        if (in_data) begin
            case (parse_phase_reg)
                bmsrfp_pkg::PH_TYPE: begin
                    current_type_next    = data_byte;
                    value_acc_next       = 32'd0;
                    element_counter_next = 8'd0;
                    if (kl_b.kind == bmsrfp_pkg::K_CELL) begin
                        parse_phase_next = bmsrfp_pkg::PH_CELLCOUNT;
                    end else if (kl_b.kind == bmsrfp_pkg::K_STR) begin
                        bytes_left_next  = kl_b.len;
                        parse_phase_next = bmsrfp_pkg::PH_STRING;
                    end else if (kl_b.kind != bmsrfp_pkg::K_NONE) begin
                        bytes_left_next  = kl_b.len;
                        parse_phase_next = bmsrfp_pkg::PH_VALUE;
                    end
                end
                bmsrfp_pkg::PH_VALUE: begin
                    value_acc_next  = {value_acc_reg[23:0], data_byte};
                    bytes_left_next = bl_dec;
                    if (bl_dec == 5'd0) begin
                        parse_phase_next = bmsrfp_pkg::PH_TYPE;
                        field_fire = !(kl_cur.kind == bmsrfp_pkg::K_CUR &&
                                       protocol_version != 8'd0 && protocol_version != 8'd1);
                    end
                end
                bmsrfp_pkg::PH_CELLCOUNT: begin
                    // number of cells from the count byte
                    cells_left_next  = div3_prod[15:9];
                    parse_phase_next = (data_byte >= 8'd3) ? bmsrfp_pkg::PH_CELLIDX
                                                           : bmsrfp_pkg::PH_TYPE;
                end
                bmsrfp_pkg::PH_CELLIDX: begin
                    element_counter_next = data_byte;
                    value_acc_next       = 32'd0;
                    bytes_left_next      = 5'd2;
                    parse_phase_next     = bmsrfp_pkg::PH_CELLVAL;
                end
                bmsrfp_pkg::PH_CELLVAL: begin
                    value_acc_next  = {16'd0, value_acc_reg[7:0], data_byte};
                    bytes_left_next = bl_dec;
                    if (bl_dec == 5'd0) begin
                        field_fire = 1'b1;
                        field_idx  = element_counter_reg;
                        if (cells_left_reg != 7'd0) cells_left_next = cells_left_reg - 7'd1;
                        parse_phase_next = (cells_left_reg > 7'd1) ? bmsrfp_pkg::PH_CELLIDX
                                                                   : bmsrfp_pkg::PH_TYPE;
                    end
                end
                bmsrfp_pkg::PH_STRING: begin
                    if (current_type_reg == bmsrfp_pkg::TYPE_NAME && data_byte == 8'd0)
                        str_char = 8'h20;
                    field_fire           = 1'b1;
                    field_idx            = element_counter_reg;
                    element_counter_next = element_counter_reg + 8'd1;
                    bytes_left_next      = bl_dec;
                    if (bl_dec == 5'd0) parse_phase_next = bmsrfp_pkg::PH_TYPE;
                end
                default: begin
                    parse_phase_next = bmsrfp_pkg::PH_TYPE;
                end
            endcase
        end else begin
            value_acc_next = {16'd0, value_acc_reg[7:0], data_byte};
        end
    end

    assign byte_offset_next = (off < bmsrfp_pkg::OFFSET_MAX) ? off + 17'd1 : off;

    // Verdict checks on the final byte, using the updated state
    assign hb[0] = header_word_next[15:8];
    assign hb[1] = header_word_next[7:0];
    assign hb[2] = declared_length_next[15:8];
    assign hb[3] = declared_length_next[7:0];
    assign sz     = byte_offset_next;
    assign sz_ext = {1'b0, sz};
    assign pos    = sz - 17'd5;
    assign sok    = (sz < 17'd2) ? (start_marker == 16'd0) : start_ok_next;

    always_comb begin
        sum_adj = running_sum_next;
        if (sz == 17'd5) sum_adj = sum_adj - {8'd0, hb[1]} - {8'd0, hb[2]} - {8'd0, hb[3]};
        else if (sz == 17'd6) sum_adj = sum_adj - {8'd0, hb[2]} - {8'd0, hb[3]};
        else if (sz == 17'd7) sum_adj = sum_adj - {8'd0, hb[3]};
        if (!sok) status = bmsrfp_pkg::ST_BAD_START;
        else if (sz < 17'd5 || sz_ext != dl_ext + 18'd2) status = bmsrfp_pkg::ST_BAD_LEN;
        else if (pos < 17'd4 ? (hb[pos[1:0]] != end_marker) : !end_ok_next)
            status = bmsrfp_pkg::ST_BAD_END;
        else if (sum_adj != value_acc_next[15:0]) status = bmsrfp_pkg::ST_BAD_SUM;
        else status = bmsrfp_pkg::ST_OK;
    end

    // Job to the queue
    always_comb begin
        job_valid         = in_fire && (frame_end || field_fire);
        job.is_verdict    = frame_end;
        job.field_type    = frame_end ? 8'd0 : current_type_next;
        job.element_index = frame_end ? 8'd0 : field_idx;
        job.kind          = (parse_phase_reg == bmsrfp_pkg::PH_STRING) ? bmsrfp_pkg::K_U32 :
                            (parse_phase_reg == bmsrfp_pkg::PH_CELLVAL) ? bmsrfp_pkg::K_U32 :
                            kl_cur.kind;
        job.acc           = (parse_phase_reg == bmsrfp_pkg::PH_STRING) ? {24'd0, str_char}
                                                                        : value_acc_next;
        job.version       = protocol_version;
        job.status        = frame_end ? status : 3'd0;
        if (parse_phase_reg == bmsrfp_pkg::PH_CELLVAL) job.field_type = frame_end ? 8'd0
                                                                  : bmsrfp_pkg::TYPE_CELL;
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn || (in_fire && frame_end)) begin
            byte_offset_reg     <= 17'd0;
            declared_length_reg <= 16'd0;
            running_sum_reg     <= 16'd0;
            header_word_reg     <= 16'd0;
            start_ok_reg        <= 1'b0;
            end_ok_reg          <= 1'b0;
            parse_phase_reg     <= bmsrfp_pkg::PH_TYPE;
            current_type_reg    <= 8'd0;
            bytes_left_reg      <= 5'd0;
            value_acc_reg       <= 32'd0;
            cells_left_reg      <= 7'd0;
            element_counter_reg <= 8'd0;
        end else if (in_fire) begin
            byte_offset_reg     <= byte_offset_next;
            declared_length_reg <= declared_length_next;
            running_sum_reg     <= running_sum_next;
            header_word_reg     <= header_word_next;
            start_ok_reg        <= start_ok_next;
            end_ok_reg          <= end_ok_next;
            parse_phase_reg     <= parse_phase_next;
            current_type_reg    <= current_type_next;
            bytes_left_reg      <= bytes_left_next;
            value_acc_reg       <= value_acc_next;
            cells_left_reg      <= cells_left_next;
            element_counter_reg <= element_counter_next;
        end
    end

    // No field job leaves a frame with a bad start marker
    a_no_field_bad_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (job_valid && !job.is_verdict) |-> start_ok_next)
        else $error("field job without valid start marker");
    // Offset never passes its saturation value and returns to zero after a verdict
    a_offset_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && frame_end) |=> (byte_offset_reg == 17'd0))
        else $error("offset not cleared after frame end");
    a_phase_idle_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_offset_reg < bmsrfp_pkg::DATA_START) |-> (parse_phase_reg == bmsrfp_pkg::PH_TYPE))
        else $error("parser active before data section");

endmodule
`default_nettype wire

### rtl/core/bmsrfp_queue.sv
// Two-entry job queue between front and back end.
// Depends on bmsrfp_pkg for the job type.
`default_nettype none
module bmsrfp_queue (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         wr_en,
    input  bmsrfp_pkg::job_t  wr_job,
    output logic              full,
    output logic              rd_valid,
    input  wire logic         rd_en,
    output bmsrfp_pkg::job_t  rd_job
);

    bmsrfp_pkg::job_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_job   = mem_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (wr_en) mem_reg[wr_ptr_reg] <= wr_job;
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (wr_en) wr_ptr_reg <= ~wr_ptr_reg;
            if (rd_en) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (!full || rd_en))
        else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> rd_valid)
        else $error("job queue underflow");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("job queue count out of range");

endmodule
`default_nettype wire

### rtl/core/bmsrfp_back.sv
// Back end: value conversion by field kind and the output register.
// Depends on bmsrfp_pkg; takes jobs from bmsrfp_queue.
`default_nettype none
module bmsrfp_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              job_valid,
    input  bmsrfp_pkg::job_t       job,
    output logic                   job_take,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_is_verdict,
    output logic [7:0]             m_field_type,
    output logic [7:0]             m_element_index,
    output logic signed [32:0]     m_field_value,
    output logic [2:0]             m_frame_status
);

    logic               valid_reg;
    logic               is_verdict_reg;
    logic [7:0]         field_type_reg;
    logic [7:0]         element_index_reg;
    logic signed [32:0] field_value_reg;
    logic [2:0]         frame_status_reg;
    logic signed [32:0] value_next;
    logic [15:0]        a16;
    logic [15:0]        neg16;
    logic signed [32:0] mag10;
    logic signed [32:0] a10;

    assign a16      = job.acc[15:0];
    assign neg16    = 16'd0 - (a16 - 16'd100);
    assign a10      = 33'(signed'({17'd0, a16})) * 33'sd10;
    assign mag10    = 33'(signed'({18'd0, a16[14:0]})) * 33'sd10;
    assign job_take = job_valid && (!valid_reg || m_ready);

    // Conversion by kind
    always_comb begin
        case (job.kind)
            bmsrfp_pkg::K_BOOL:   value_next = (job.acc != 32'd0) ? 33'sd1 : 33'sd0;
            bmsrfp_pkg::K_U16X10: value_next = a10;
            bmsrfp_pkg::K_S16:    value_next = 33'(signed'(a16));
            bmsrfp_pkg::K_TEMP:   value_next = (a16 <= 16'd100) ? 33'(signed'({17'd0, a16}))
                                                                : 33'(signed'(neg16));
            bmsrfp_pkg::K_CUR: begin
                if (job.version == 8'd0) value_next = 33'sd100000 - a10;
                else value_next = a16[15] ? mag10 : -mag10;
            end
            default:              value_next = 33'(signed'({1'b0, job.acc}));
        endcase
        if (job.is_verdict) value_next = 33'sd0;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (job_take) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (job_take) begin
            is_verdict_reg    <= job.is_verdict;
            field_type_reg    <= job.field_type;
            element_index_reg <= job.element_index;
            field_value_reg   <= value_next;
            frame_status_reg  <= job.status;
        end
    end

    assign m_valid         = valid_reg;
    assign m_is_verdict    = is_verdict_reg;
    assign m_field_type    = field_type_reg;
    assign m_element_index = element_index_reg;
    assign m_field_value   = field_value_reg;
    assign m_frame_status  = frame_status_reg;

    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped under stall");
    a_take_room: assert property (@(posedge aclk) disable iff (!aresetn)
        job_take |-> (!valid_reg || m_ready))
        else $error("job taken over pending result");
    a_verdict_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_verdict) |-> (m_field_value == 33'sd0))
        else $error("verdict carries a value");

endmodule
`default_nettype wire

### rtl/core/bms_response_frame_parser_core.sv
// Top level of the battery-monitor response frame parser.
// Depends on bmsrfp_pkg, bmsrfp_front, bmsrfp_queue and bmsrfp_back.
//
// Usage: frame bytes enter on the s_ channel (valid/ready), one per cycle,
// s_frame_end marking the last byte of a frame. Decoded field items and one
// verdict per frame leave on the m_ channel (valid/ready); field items are
// provisional until the verdict reports the frame status.
// Result path: the front tokenizer writes a job into the job queue, then the
// conversion register in the back end takes it from there.
// Throughput: one byte per cycle; each byte yields at most one result.
// The front stalls only when the two-entry job queue is full, which happens
// only when the receiver holds m_ready low.
// Registers on the APB port: start marker at 0x0, end marker at 0x4,
// protocol version at 0x8; pready is always high.
// Reset (aresetn low, synchronous) restores register defaults, clears the
// frame state and empties the queue and output register.
`default_nettype none
module bms_response_frame_parser_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_data_byte,
    input  wire logic               s_frame_end,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_is_verdict,
    output logic [7:0]              m_field_type,
    output logic [7:0]              m_element_index,
    output logic signed [32:0]      m_field_value,
    output logic [2:0]              m_frame_status,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [15:0] start_marker_reg;
    logic [7:0]  end_marker_reg;
    logic [7:0]  version_reg;
    logic        in_fire;
    logic        fj_valid;
    bmsrfp_pkg::job_t fj;
    logic        q_full;
    logic        q_valid;
    logic        q_take;
    bmsrfp_pkg::job_t qj;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_marker_reg <= 16'h4E57;
            end_marker_reg   <= 8'h68;
            version_reg      <= 8'd1;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                bmsrfp_pkg::REG_START: start_marker_reg <= pwdata[15:0];
                bmsrfp_pkg::REG_END:   end_marker_reg   <= pwdata[7:0];
                bmsrfp_pkg::REG_VER:   version_reg      <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            bmsrfp_pkg::REG_START: prdata = {16'd0, start_marker_reg};
            bmsrfp_pkg::REG_END:   prdata = {24'd0, end_marker_reg};
            bmsrfp_pkg::REG_VER:   prdata = {24'd0, version_reg};
            default:               prdata = 32'd0;
        endcase
    end

    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;

    bmsrfp_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_fire          (in_fire),
        .data_byte        (s_data_byte),
        .frame_end        (s_frame_end),
        .start_marker     (start_marker_reg),
        .end_marker       (end_marker_reg),
        .protocol_version (version_reg),
        .job_valid        (fj_valid),
        .job              (fj)
    );

    bmsrfp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (fj_valid),
        .wr_job   (fj),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_en    (q_take),
        .rd_job   (qj)
    );

    bmsrfp_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .job_valid       (q_valid),
        .job             (qj),
        .job_take        (q_take),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_is_verdict    (m_is_verdict),
        .m_field_type    (m_field_type),
        .m_element_index (m_element_index),
        .m_field_value   (m_field_value),
        .m_frame_status  (m_frame_status)
    );

endmodule
`default_nettype wire
